// ===== hw/rtl/pbi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pbi_pkg;

  // Palette depth and the widths that follow from it
  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = ADDR_W + 1;

  // Fixed field widths
  localparam int PIX_W    = 8;
  localparam int CHAN_W   = 6;
  localparam int COLOUR_W = 3 * CHAN_W;
  localparam int INDEX_W  = 8;
  localparam int USED_W   = 9;

  // Sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  typedef struct packed {
    logic              first_pixel;
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } colour_t;

  typedef struct packed {
    logic [INDEX_W-1:0] palette_index;
    logic               new_entry;
    colour_t            colour;
    logic               overflow;
    logic [USED_W-1:0]  entries_used;
  } result_t;

  // Drop the two low bits of each channel
  function automatic colour_t quantise(input pixel_t p);
    colour_t c;
    c.red   = p.red[PIX_W-1:2];
    c.green = p.green[PIX_W-1:2];
    c.blue  = p.blue[PIX_W-1:2];
    return c;
  endfunction

  // Entry index reported on 8 bits
  function automatic logic [INDEX_W-1:0] to_index(input logic [ADDR_W-1:0] a);
    logic [ADDR_W+INDEX_W-1:0] w;
    w = {{INDEX_W{1'b0}}, a};
    return w[INDEX_W-1:0];
  endfunction

  // Fill count reported on 9 bits
  function automatic logic [USED_W-1:0] to_used(input logic [CNT_W-1:0] c);
    logic [CNT_W+USED_W-1:0] w;
    w = {{USED_W{1'b0}}, c};
    return w[USED_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pbi_pix_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pbi_pix_if;
  logic                      valid;
  logic                      ready;
  logic                      first_pixel;
  logic [pbi_pkg::PIX_W-1:0] pixel_red;
  logic [pbi_pkg::PIX_W-1:0] pixel_green;
  logic [pbi_pkg::PIX_W-1:0] pixel_blue;

  modport source (output valid, first_pixel, pixel_red, pixel_green, pixel_blue,
                  input ready);
  modport sink   (input valid, first_pixel, pixel_red, pixel_green, pixel_blue,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pbi_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pbi_res_if;
  logic                        valid;
  logic                        ready;
  logic [pbi_pkg::INDEX_W-1:0] palette_index;
  logic                        new_entry;
  logic [pbi_pkg::CHAN_W-1:0]  entry_red;
  logic [pbi_pkg::CHAN_W-1:0]  entry_green;
  logic [pbi_pkg::CHAN_W-1:0]  entry_blue;
  logic                        overflow;
  logic [pbi_pkg::USED_W-1:0]  entries_used;

  modport source (output valid, palette_index, new_entry, entry_red, entry_green,
                  entry_blue, overflow, entries_used, input ready);
  modport sink   (input valid, palette_index, new_entry, entry_red, entry_green,
                  entry_blue, overflow, entries_used, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pbi_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbi_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 256
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pbi_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbi_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire pbi_pkg::pixel_t                  in_pixel,
  output      logic                             res_valid,
  input  wire logic                             res_take,
  output      pbi_pkg::result_t                 res_data,
  output      logic                             ram_we,
  output      logic [pbi_pkg::ADDR_W-1:0]       ram_waddr,
  output      logic [pbi_pkg::COLOUR_W-1:0]     ram_wdata,
  output      logic [pbi_pkg::ADDR_W-1:0]       ram_raddr,
  input  wire logic [pbi_pkg::COLOUR_W-1:0]     ram_rdata
);

  localparam logic [pbi_pkg::CNT_W-1:0] DEPTH_C = pbi_pkg::CNT_W'(pbi_pkg::TABLE_DEPTH);
  localparam logic [pbi_pkg::CNT_W-1:0] ONE_C   = pbi_pkg::CNT_W'(1);

  logic [1:0]                  state;
  logic [pbi_pkg::CNT_W-1:0]   fill_count;
  logic                        overflowed;
  pbi_pkg::colour_t            key;
  logic [pbi_pkg::CNT_W-1:0]   scan_addr;
  logic [pbi_pkg::ADDR_W-1:0]  cmp_idx;
  logic                        cmp_pend;
  pbi_pkg::result_t            result;

  logic issue, hit, miss, full;

  // One read issued per cycle; its data is compared in the next cycle
  assign issue = scan_addr < fill_count;
  assign hit   = cmp_pend && (ram_rdata == key);
  assign miss  = !issue && !cmp_pend && !hit;
  assign full  = fill_count >= DEPTH_C;

  assign in_ready  = (state == pbi_pkg::ST_IDLE);
  assign res_valid = (state == pbi_pkg::ST_RESULT);
  assign res_data  = result;

  assign ram_raddr = scan_addr[pbi_pkg::ADDR_W-1:0];
  assign ram_waddr = fill_count[pbi_pkg::ADDR_W-1:0];
  assign ram_wdata = key;
  assign ram_we    = (state == pbi_pkg::ST_SCAN) && miss && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pbi_pkg::ST_IDLE;
      fill_count <= '0;
      overflowed <= 1'b0;
      cmp_pend   <= 1'b0;
    end else begin
      case (state)
        pbi_pkg::ST_IDLE: begin
          if (in_valid) begin
            key       <= pbi_pkg::quantise(in_pixel);
            scan_addr <= '0;
            cmp_pend  <= 1'b0;
            if (in_pixel.first_pixel) begin
              fill_count <= '0;
              overflowed <= 1'b0;
              state      <= pbi_pkg::ST_SCAN;
            end else if (overflowed) begin
              // sticky overflow: no search
              result.palette_index <= '0;
              result.new_entry     <= 1'b0;
              result.colour        <= pbi_pkg::quantise(in_pixel);
              result.overflow      <= 1'b1;
              result.entries_used  <= pbi_pkg::to_used(fill_count);
              state                <= pbi_pkg::ST_RESULT;
            end else begin
              state <= pbi_pkg::ST_SCAN;
            end
          end
        end
        pbi_pkg::ST_SCAN: begin
          cmp_pend <= issue && !hit;
          if (issue) begin
            scan_addr <= scan_addr + ONE_C;
            cmp_idx   <= scan_addr[pbi_pkg::ADDR_W-1:0];
          end
          result.colour <= key;
          if (hit) begin
            result.palette_index <= pbi_pkg::to_index(cmp_idx);
            result.new_entry     <= 1'b0;
            result.overflow      <= 1'b0;
            result.entries_used  <= pbi_pkg::to_used(fill_count);
            state                <= pbi_pkg::ST_RESULT;
          end else if (miss) begin
            if (full) begin
              overflowed           <= 1'b1;
              result.palette_index <= '0;
              result.new_entry     <= 1'b0;
              result.overflow      <= 1'b1;
              result.entries_used  <= pbi_pkg::to_used(fill_count);
            end else begin
              fill_count           <= fill_count + ONE_C;
              result.palette_index <= pbi_pkg::to_index(fill_count[pbi_pkg::ADDR_W-1:0]);
              result.new_entry     <= 1'b1;
              result.overflow      <= 1'b0;
              result.entries_used  <= pbi_pkg::to_used(fill_count + ONE_C);
            end
            state <= pbi_pkg::ST_RESULT;
          end
        end
        pbi_pkg::ST_RESULT: begin
          if (res_take) begin
            state <= pbi_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= pbi_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/palette_builder_indexer_core.sv =====
// A taken pixel is quantised and searched for by a linear scan over the filled part of the
//   colour table, one RAM read per cycle: a hit gives the matching entry, a miss appends
//   the colour or, with the table full, sets the sticky overflow flag. An overflowed pixel
//   skips the scan. The scan sets the pace; a new pixel is taken only once the last result
//   is in the output beat register, and a sink that holds off stalls the sequencer.
// Reset: fill count and overflow flag cleared, output empty; table contents are left
//   undefined and only entries below the fill count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module palette_builder_indexer_core (
  input  wire logic clk,
  input  wire logic rst,
  pbi_pix_if.sink   pix,
  pbi_res_if.source res
);

  pbi_pkg::pixel_t                   in_pixel;
  pbi_pkg::result_t                  ctrl_res;
  logic                              ctrl_res_valid;
  logic                              res_take;

  logic                              ram_we;
  logic [pbi_pkg::ADDR_W-1:0]        ram_waddr;
  logic [pbi_pkg::ADDR_W-1:0]        ram_raddr;
  logic [pbi_pkg::COLOUR_W-1:0]      ram_wdata;
  logic [pbi_pkg::COLOUR_W-1:0]      ram_rdata;

  // Output beat register, parts the sequencer from the sink
  logic                              out_valid;
  pbi_pkg::result_t                  out_data;

  assign in_pixel.first_pixel = pix.first_pixel;
  assign in_pixel.red         = pix.pixel_red;
  assign in_pixel.green       = pix.pixel_green;
  assign in_pixel.blue        = pix.pixel_blue;

  // Sequencer: search, append and overflow handling
  pbi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .in_pixel  (in_pixel),
    .res_valid (ctrl_res_valid),
    .res_take  (res_take),
    .res_data  (ctrl_res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Colour table: one write and one registered read per cycle
  pbi_ram #(
    .WIDTH (pbi_pkg::COLOUR_W),
    .DEPTH (pbi_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Load a finished result when the output is empty or being drained
  assign res_take = ctrl_res_valid && (!out_valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= ctrl_res;
    end
  end

  assign res.valid         = out_valid;
  assign res.palette_index = out_data.palette_index;
  assign res.new_entry     = out_data.new_entry;
  assign res.entry_red     = out_data.colour.red;
  assign res.entry_green   = out_data.colour.green;
  assign res.entry_blue    = out_data.colour.blue;
  assign res.overflow      = out_data.overflow;
  assign res.entries_used  = out_data.entries_used;

endmodule

`default_nettype wire

// ===== hw/rtl/pbi_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbi_chk (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        res_valid,
  input wire logic                        res_ready,
  input wire logic [pbi_pkg::INDEX_W-1:0] palette_index,
  input wire logic                        new_entry,
  input wire logic                        overflow,
  input wire logic [pbi_pkg::USED_W-1:0]  entries_used
);

  logic [pbi_pkg::USED_W-1:0] used_less_one;
  assign used_less_one = entries_used - pbi_pkg::USED_W'(1);

  // A pending beat is held until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat dropped while stalled");

  // An overflowed pixel never carries an index or a new entry
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    res_valid && overflow |-> (palette_index == '0) && !new_entry)
    else $error("overflow beat with index or new entry");

  // A new entry is the last one filled
  a_new: assert property (@(posedge clk) disable iff (rst)
    res_valid && new_entry |-> (used_less_one[pbi_pkg::INDEX_W-1:0] == palette_index)
                               && (entries_used != '0))
    else $error("new entry index does not match fill count");

  // Nothing shown straight after reset
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result beat straight after reset");

endmodule

bind palette_builder_indexer_core pbi_chk u_pbi_chk (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .palette_index (res.palette_index),
  .new_entry     (res.new_entry),
  .overflow      (res.overflow),
  .entries_used  (res.entries_used)
);

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

  // Run sizing
  localparam int RANDOM_PIXELS   = 1600;
  localparam int QUIET_TAIL      = 300;   // images begun in the last random pixels run with no idling
  localparam int HOLD_OFF_CYCLES = 800;   // long sink stall for the pressure test
  localparam int TAIL_CYCLES     = 300;   // a full-table scan plus margin
  // Longest correct stretch with no beat on either side: the hold-off plus one full
  // scan and a sender gap and a sink stall, taken four times over.
  localparam int WATCHDOG_LIMIT  = 5000;

  logic clk;
  logic rst;

  pbi_pix_if pix_bus ();
  pbi_res_if res_bus ();

  palette_builder_indexer_core u_top (
    .clk (clk),
    .rst (rst),
    .pix (pix_bus),
    .res (res_bus)
  );

  // Shadow of the block's state: stored colours, fill count, sticky overflow
  pbi_pkg::colour_t palette_shadow [pbi_pkg::TABLE_DEPTH];
  int      palette_fill;
  bit      palette_overflowed;

  pbi_pkg::result_t expected_results [$];

  // Idling controls, changed between images
  bit source_gaps_on;
  bit sink_stalls_on;
  int hold_off_request;

  int mismatch_count;
  int pixels_sent;
  int results_checked;
  int new_entries_seen;
  int hits_seen;
  int overflow_results_seen;
  int stuck_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Palette prediction: quantise, search the filled part lowest index first, append on a
  // miss, and go sticky-overflowed when a new colour meets a full table.
  function automatic pbi_pkg::result_t index_pixel(input pbi_pkg::pixel_t px);
    pbi_pkg::result_t r;
    pbi_pkg::colour_t c;
    bit      hit;
    r = '0;
    hit = 1'b0;
    c.red   = px.red[pbi_pkg::PIX_W-1:2];
    c.green = px.green[pbi_pkg::PIX_W-1:2];
    c.blue  = px.blue[pbi_pkg::PIX_W-1:2];
    // a new image restarts the fill; old entries stay but are beyond the count
    if (px.first_pixel) begin
      palette_fill = 0;
      palette_overflowed = 1'b0;
    end
    r.colour = c;
    // once overflowed no search is made: index 0, no new entry
    if (!palette_overflowed) begin
      for (int k = 0; k < palette_fill; k++) begin
        if (!hit && palette_shadow[k] == c) begin
          hit = 1'b1;
          r.palette_index = pbi_pkg::INDEX_W'(k);
        end
      end
      if (!hit) begin
        if (palette_fill >= pbi_pkg::TABLE_DEPTH) begin
          palette_overflowed = 1'b1;
        end else begin
          palette_shadow[palette_fill] = c;
          r.palette_index = pbi_pkg::INDEX_W'(palette_fill);
          r.new_entry = 1'b1;
          palette_fill++;
        end
      end
    end
    r.overflow = palette_overflowed;
    r.entries_used = pbi_pkg::USED_W'(palette_fill);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    // cap the log on a badly broken block; the count still runs
    if (mismatch_count <= 200) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // Offer one pixel beat and hold it until taken; the prediction is made on the taking
  // edge, so the queue order is the acceptance order. Valid is left high for the next
  // beat; whoever idles next lowers it.
  task automatic send_pixel(input bit first, input logic [pbi_pkg::PIX_W-1:0] r,
                            input logic [pbi_pkg::PIX_W-1:0] g,
                            input logic [pbi_pkg::PIX_W-1:0] b);
    pbi_pkg::pixel_t px;
    if (source_gaps_on && $urandom_range(0, 5) == 0) begin
      pix_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    pix_bus.valid       <= 1'b1;
    pix_bus.first_pixel <= first;
    pix_bus.pixel_red   <= r;
    pix_bus.pixel_green <= g;
    pix_bus.pixel_blue  <= b;
    do @(posedge clk); while (pix_bus.ready !== 1'b1);
    px.first_pixel = first;
    px.red   = r;
    px.green = g;
    px.blue  = b;
    expected_results.push_back(index_pixel(px));
    pixels_sent++;
  endtask

  // Sender pause: stop offering and wait until every predicted result beat has arrived.
  // The task always waits on the clock, so valid never gets two assignments in one step.
  task automatic drain_results();
    pix_bus.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Quantisation edges, single-channel steps, reset state and image restarts
  task automatic test_quantisation_edges();
    send_pixel(1'b0, 8'h00, 8'h00, 8'h00);  // straight after reset, no marker: new at 0
    send_pixel(1'b0, 8'h03, 8'h03, 8'h03);  // only low bits differ: hit 0
    send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);  // new at 1
    send_pixel(1'b0, 8'hFC, 8'hFD, 8'hFE);  // hit 1
    send_pixel(1'b0, 8'h04, 8'h00, 8'h00);  // one step on red alone
    send_pixel(1'b0, 8'h00, 8'h04, 8'h00);
    send_pixel(1'b0, 8'h00, 8'h00, 8'h04);
    send_pixel(1'b0, 8'hAA, 8'h55, 8'hAA);
    send_pixel(1'b0, 8'h55, 8'hAA, 8'h55);
    send_pixel(1'b0, 8'h80, 8'h40, 8'h20);
    send_pixel(1'b0, 8'h01, 8'h02, 8'h03);  // hit 0 again
    send_pixel(1'b0, 8'hAB, 8'h56, 8'hA9);  // hit the 0xAA/0x55 entry
    // new image: the old entries are still stored but must not be found
    send_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(1'b0, 8'h00, 8'h00, 8'h00);
    send_pixel(1'b0, 8'hFF, 8'hFE, 8'hFD);
    // markers back to back
    send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
    send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
    send_pixel(1'b0, 8'h7F, 8'hBF, 8'hDF);
    drain_results();
  endtask

  // Fill every entry, hit at both ends of a full table, overflow, stay sticky, then clear
  // the flag with a marker.
  task automatic test_table_overflow();
    logic [7:0]  slot;
    logic [23:0] first_colour;
    logic [23:0] last_colour;
    logic [23:0] c;
    for (int k = 0; k < pbi_pkg::TABLE_DEPTH; k++) begin
      slot = 8'(k);
      // the slot number makes each colour unique; blue stays quantised to 0
      c = {slot[5:0], 2'($urandom), 4'($urandom), slot[7:6], 2'($urandom),
           6'd0, 2'($urandom)};
      if (k == 0) first_colour = c;
      last_colour = c;
      send_pixel(k == 0, c[23:16], c[15:8], c[7:0]);
    end
    send_pixel(1'b0, last_colour[23:16], last_colour[15:8], last_colour[7:0]);
    send_pixel(1'b0, first_colour[23:16], first_colour[15:8], first_colour[7:0]);
    send_pixel(1'b0, 8'h12, 8'h34, 8'hFF);  // new colour into a full table
    send_pixel(1'b0, first_colour[23:16], first_colour[15:8], first_colour[7:0]);
    repeat (4) send_pixel(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
    send_pixel(1'b1, 8'h12, 8'h34, 8'hFF);  // marker clears the flag
    send_pixel(1'b0, 8'h12, 8'h35, 8'hFE);
    drain_results();
  endtask

  // Sink holds off for a long stretch while pixels keep coming, so the block backs up
  // and stalls its input; then the sender pauses until everything is out.
  task automatic test_output_hold_off();
    logic [23:0] pool [4];
    logic [23:0] c;
    foreach (pool[i]) pool[i] = 24'($urandom);
    hold_off_request = HOLD_OFF_CYCLES;
    for (int i = 0; i < 40; i++) begin
      c = pool[$urandom_range(0, 3)];
      send_pixel(i == 0, c[23:16], c[15:8], c[7:0]);
    end
    drain_results();
  endtask

  // Random images: mostly a small pool of colours with random low bits so hits dominate,
  // some noise pixels, the odd stray marker, images that carry on without a marker, and
  // now and then a large pool that runs the table full.
  task automatic test_random_images();
    logic [23:0] pool [$];
    logic [23:0] c;
    int          pool_size;
    int          length;
    int          sent;
    bit          large_pool;
    bit          start_marker;
    bit          quiet;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      quiet = (sent >= RANDOM_PIXELS - QUIET_TAIL);
      source_gaps_on = !quiet && ($urandom_range(0, 3) != 0);
      sink_stalls_on = !quiet && ($urandom_range(0, 3) != 0);
      large_pool = ($urandom_range(0, 14) == 0);
      pool_size = large_pool ? $urandom_range(200, 300) : $urandom_range(1, 24);
      pool.delete();
      repeat (pool_size) pool.push_back(24'($urandom));
      length = large_pool ? pool_size + $urandom_range(5, 40) : $urandom_range(1, 60);
      start_marker = ($urandom_range(0, 7) != 0);
      for (int i = 0; i < length; i++) begin
        if (large_pool && i < pool_size) c = pool[i];
        else if ($urandom_range(0, 9) == 0) c = 24'($urandom);
        else c = pool[$urandom_range(0, pool_size - 1)];
        c[17:16] = 2'($urandom);
        c[9:8]   = 2'($urandom);
        c[1:0]   = 2'($urandom);
        send_pixel((i == 0) ? start_marker : ($urandom_range(0, 63) == 0),
                   c[23:16], c[15:8], c[7:0]);
        sent++;
      end
      if (!quiet && $urandom_range(0, 5) == 0) drain_results();
    end
  endtask

  // Result sink: ready with random stall bursts, or one long counted hold-off on request
  initial begin : result_sink
    int stall;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request != 0) begin
        stall = hold_off_request;
        hold_off_request = 0;
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        res_bus.ready <= 1'b1;
      end else if (sink_stalls_on && $urandom_range(0, 9) == 0) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        res_bus.ready <= 1'b1;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // Each result beat against the oldest prediction, field by field
  always @(posedge clk) begin : check_results
    pbi_pkg::result_t want;
    if (!rst && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with no pixel waiting for it");
      end else begin
        want = expected_results.pop_front();
        if (res_bus.palette_index !== want.palette_index)
          report_mismatch($sformatf("result %0d: palette_index %0d, want %0d",
                                    results_checked, res_bus.palette_index,
                                    want.palette_index));
        if (res_bus.new_entry !== want.new_entry)
          report_mismatch($sformatf("result %0d: new_entry %0b, want %0b",
                                    results_checked, res_bus.new_entry, want.new_entry));
        if (res_bus.entry_red !== want.colour.red)
          report_mismatch($sformatf("result %0d: entry_red %0d, want %0d",
                                    results_checked, res_bus.entry_red, want.colour.red));
        if (res_bus.entry_green !== want.colour.green)
          report_mismatch($sformatf("result %0d: entry_green %0d, want %0d",
                                    results_checked, res_bus.entry_green,
                                    want.colour.green));
        if (res_bus.entry_blue !== want.colour.blue)
          report_mismatch($sformatf("result %0d: entry_blue %0d, want %0d",
                                    results_checked, res_bus.entry_blue, want.colour.blue));
        if (res_bus.overflow !== want.overflow)
          report_mismatch($sformatf("result %0d: overflow %0b, want %0b",
                                    results_checked, res_bus.overflow, want.overflow));
        if (res_bus.entries_used !== want.entries_used)
          report_mismatch($sformatf("result %0d: entries_used %0d, want %0d",
                                    results_checked, res_bus.entries_used,
                                    want.entries_used));
        results_checked++;
        if (want.new_entry) new_entries_seen++;
        else if (want.overflow) overflow_results_seen++;
        else hits_seen++;
      end
    end
  end

  // Watchdog: too long with no beat taken on either side ends the run
  always @(posedge clk) begin
    if (rst || (pix_bus.valid === 1'b1 && pix_bus.ready === 1'b1) ||
        (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("TIMEOUT @%0t: no beat for %0d cycles, %0d results outstanding",
               $time, stuck_cycles, expected_results.size());
      $display("palette_builder_indexer_core regression: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    pix_bus.valid       <= 1'b0;
    pix_bus.first_pixel <= 1'b0;
    pix_bus.pixel_red   <= '0;
    pix_bus.pixel_green <= '0;
    pix_bus.pixel_blue  <= '0;
    // shadow starts as the block does after reset
    palette_fill = 0;
    palette_overflowed = 1'b0;
    source_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    hold_off_request = 0;
    mismatch_count = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_quantisation_edges();
    test_table_overflow();
    test_output_hold_off();
    test_random_images();

    // everything in: wait for the stragglers, then watch for stray beats
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d pixels, checked %0d results: %0d new entries, %0d hits, %0d overflowed.",
             pixels_sent, results_checked, new_entries_seen, hits_seen,
             overflow_results_seen);
    $display("Covered full-table hits and overflow, image restarts, a long output hold-off.");
    if (mismatch_count == 0) begin
      $display("palette_builder_indexer_core regression: pass");
    end else begin
      $display("palette_builder_indexer_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/pbi_pkg.sv
hw/rtl/pbi_pix_if.sv
hw/rtl/pbi_res_if.sv
hw/rtl/pbi_ram.sv
hw/rtl/pbi_ctrl.sv
hw/rtl/palette_builder_indexer_core.sv
hw/rtl/pbi_chk.sv
test/tb.sv
